// File: hdl/bsp_pkg.sv
// shared types and constants for the billboard sprite projector
// payload structs, register indexes, controller commands and datapath status
// no dependencies
`default_nettype none

package bsp_pkg;

   // configuration port geometry
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAYER_X      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAYER_Y      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_X         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIR_Y         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_X       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_Y       = 3'd7;

   // register reset values
   localparam logic [12:0]        RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [12:0]        RST_SCREEN_HEIGHT = 13'd480;
   localparam logic signed [31:0] RST_PLAYER_X      = 32'sd0;
   localparam logic signed [31:0] RST_PLAYER_Y      = 32'sd0;
   localparam logic signed [31:0] RST_DIR_X         = 32'sd65536;
   localparam logic signed [31:0] RST_DIR_Y         = 32'sd0;
   localparam logic signed [31:0] RST_PLANE_X       = 32'sd0;
   localparam logic signed [31:0] RST_PLANE_Y       = 32'sd43254;

   // input item opcodes
   localparam logic OP_SPRITE = 1'b0;
   localparam logic OP_COLUMN = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] sprite_x;
      logic signed [31:0] sprite_y;
      logic        [11:0] column;
      logic        [31:0] wall_depth;
   } req_type;

   typedef struct packed {
      logic        draw;
      logic [11:0] col_start;
      logic [11:0] col_end;
      logic [11:0] row_start;
      logic [11:0] row_end;
      logic [11:0] tex_col;
      logic [31:0] tex_row_start;
      logic [31:0] tex_row_step;
   } rsp_type;

   typedef struct packed {
      logic        [12:0] screen_width;
      logic        [12:0] screen_height;
      logic signed [31:0] player_x;
      logic signed [31:0] player_y;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] plane_x;
      logic signed [31:0] plane_y;
   } cfg_type;

   // datapath actions
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_REL,
      ACT_MUL,
      ACT_ACC,
      ACT_CLEAR_ALL,
      ACT_CLEAR_KEEP,
      ACT_CENTRE_MUL,
      ACT_DIV_START,
      ACT_DIV_STORE,
      ACT_GEOM,
      ACT_COL_EVAL,
      ACT_RSP_LOAD
   } act_type;

   // divisions done by the shared divider
   typedef enum logic [2:0] {
      DIV_DEPTH,
      DIV_CENTRE,
      DIV_SIZE,
      DIV_STEP,
      DIV_TEXCOL,
      DIV_TEXROW
   } div_op_type;

   // product terms of the camera transform
   typedef enum logic [2:0] {
      MT_DET_A,
      MT_DET_B,
      MT_NX_A,
      MT_NX_B,
      MT_NY_A,
      MT_NY_B
   } mterm_type;

   typedef struct packed {
      act_type    act;
      div_op_type div_op;
      mterm_type  mterm;
   } cmd_type;

   typedef struct packed {
      logic is_column;
      logic proj_bad;
      logic depth_zero;
      logic size_zero;
      logic draw;
      logic texcol_pos;
      logic texrow_pos;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/bsp_div.sv
// restoring divider, one quotient bit per cycle
// 64-bit dividend aligned to the top, 48-bit divisor, programmable bit count
// no dependencies
`default_nettype none

module bsp_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [47:0] divisor,
   input  wire logic [6:0]  count,
   output logic             done,
   output logic [63:0]      quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [6:0]  cnt_ff;
   logic [47:0] rem_ff;
   logic [63:0] quo_ff;
   logic [47:0] dvs_ff;
   logic [48:0] rem_sh;
   logic [48:0] rem_dif;
   logic        q_bit;

   // trial subtract
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[63]};
      rem_dif = rem_sh - {1'b0, dvs_ff};
      q_bit   = (rem_sh >= {1'b0, dvs_ff});
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= count;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= 48'd0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[62:0], q_bit};
         rem_ff <= q_bit ? rem_dif[47:0] : rem_sh[47:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      start |-> (count != 7'd0 && count <= 7'd64))
      else $error("divider bit count out of range");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a run");

endmodule

`default_nettype wire

// File: hdl/bsp_dp.sv
// datapath: camera transform, sprite state, column evaluation, result register
// uses bsp_pkg and the shared divider bsp_div
`default_nettype none

module bsp_dp #(
   parameter int unsigned TEX_W = 64,
   parameter int unsigned TEX_H = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bsp_pkg::cfg_type     cfg,
   input  wire bsp_pkg::req_type     req_data,
   input  wire bsp_pkg::cmd_type     cmd,
   output bsp_pkg::status_type       status,
   output bsp_pkg::rsp_type          rsp_data
);

   import bsp_pkg::*;

   localparam logic [12:0] TEX_W_C  = 13'(TEX_W);
   localparam logic [12:0] TEX_H_C  = 13'(TEX_H);
   localparam logic [31:0] STEP_NUM = 32'(TEX_H) << 16;

   function automatic logic [11:0] clamp12(input logic signed [34:0] v);
      logic [11:0] r;
      if (v < 0) r = 12'd0;
      else if (v > 35'sd4095) r = 12'd4095;
      else r = v[11:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat_centre(input logic [63:0] m, input logic neg);
      logic signed [31:0] r;
      if (!neg) r = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
      else r = (m > 64'h8000_0000) ? 32'sh8000_0000 : $signed(-m[31:0]);
      return r;
   endfunction

   // latched item and transform intermediates
   req_type            req_ff;
   logic signed [31:0] rx_ff, ry_ff;
   logic [63:0]        prod_ff;
   logic               pneg_ff;
   logic signed [48:0] det_ff, nx_ff, ny_ff;
   logic [31:0]        depth_tmp_ff;
   logic signed [62:0] cprod_ff;
   logic               cneg_ff;
   logic [15:0]        size_tmp_ff;
   // sprite state
   logic [31:0]        depth_ff;
   logic signed [31:0] centre_ff;
   logic [15:0]        size_ff;
   logic [11:0]        first_col_ff, end_col_ff, first_row_ff, end_row_ff;
   logic [31:0]        row_step_ff;
   // column answer
   logic               draw_ff;
   logic [11:0]        tex_col_ff;
   logic [31:0]        tex_row_ff;
   rsp_type            rsp_ff;

   logic signed [33:0] rx_sum, ry_sum;
   logic signed [31:0] op_a, op_b;
   logic [31:0]        mag_a, mag_b;
   logic [47:0]        p_hi;
   logic signed [48:0] term;
   logic [48:0]        ny_mag, det_mag;
   logic signed [49:0] nxy_sum;
   logic signed [62:0] cprod_in;
   logic [62:0]        cmag;
   logic [14:0]        half;
   logic [11:0]        hh;
   logic signed [17:0] row_a, row_b, h_s, row_a_lim, row_b_lim;
   logic signed [34:0] col_a, col_b, w_s, col_a_lim, col_b_lim;
   logic signed [34:0] tex_v;
   logic [47:0]        tex_num;
   logic signed [26:0] tex_d;
   logic [39:0]        tex_den;
   logic [55:0]        tr8;
   logic               draw_c;
   logic [63:0]        div_dividend;
   logic [47:0]        div_divisor;
   logic [6:0]         div_count;
   logic               div_done;
   logic [63:0]        div_quo;
   rsp_type            rsp_in;

   // relative position, saturated
   always_comb begin
      rx_sum = 34'(req_ff.sprite_x) - 34'(cfg.player_x) + 34'sd32768;
      ry_sum = 34'(req_ff.sprite_y) - 34'(cfg.player_y) + 34'sd32768;
   end

   // multiplier operand select
   always_comb begin
      case (cmd.mterm)
         MT_DET_A: begin op_a = cfg.plane_x; op_b = cfg.dir_y;   end
         MT_DET_B: begin op_a = cfg.dir_x;   op_b = cfg.plane_y; end
         MT_NX_A:  begin op_a = cfg.dir_y;   op_b = rx_ff;       end
         MT_NX_B:  begin op_a = cfg.dir_x;   op_b = ry_ff;       end
         MT_NY_A:  begin op_a = cfg.plane_x; op_b = ry_ff;       end
         MT_NY_B:  begin op_a = cfg.plane_y; op_b = rx_ff;       end
         default:  begin op_a = cfg.plane_x; op_b = cfg.dir_y;   end
      endcase
      mag_a = op_a[31] ? (~op_a + 32'd1) : op_a;
      mag_b = op_b[31] ? (~op_b + 32'd1) : op_b;
      p_hi  = prod_ff[63:16];
      term  = pneg_ff ? -$signed({1'b0, p_hi}) : $signed({1'b0, p_hi});
   end

   // magnitudes and centre product
   always_comb begin
      ny_mag   = ny_ff[48] ? 49'(-ny_ff) : 49'(ny_ff);
      det_mag  = det_ff[48] ? 49'(-det_ff) : 49'(det_ff);
      nxy_sum  = 50'(ny_ff) + 50'(nx_ff);
      cprod_in = 63'(nxy_sum) * 63'($signed({1'b0, cfg.screen_width[12:1]}));
      cmag     = cprod_ff[62] ? 63'(-cprod_ff) : 63'(cprod_ff);
   end

   // screen ranges from the new size and centre
   always_comb begin
      half      = size_tmp_ff[15:1];
      hh        = cfg.screen_height[12:1];
      h_s       = $signed({5'd0, cfg.screen_height});
      row_a     = $signed({6'd0, hh}) - $signed({3'd0, half});
      row_b     = $signed({6'd0, hh}) + $signed({3'd0, half});
      row_a_lim = (row_a < 0) ? 18'sd0 : row_a;
      row_b_lim = (row_b >= h_s) ? (h_s - 18'sd1) : row_b;
      w_s       = $signed({22'd0, cfg.screen_width});
      col_a     = 35'(centre_ff) - $signed({20'd0, half});
      col_b     = 35'(centre_ff) + $signed({20'd0, half});
      col_a_lim = (col_a < 0) ? 35'sd0 : col_a;
      col_b_lim = (col_b >= w_s) ? (w_s - 35'sd1) : col_b;
   end

   // column evaluation
   always_comb begin
      draw_c  = (size_ff != 16'd0) && (depth_ff != 32'd0) &&
                (req_ff.column >= first_col_ff) && (req_ff.column < end_col_ff) &&
                ({1'b0, req_ff.column} < cfg.screen_width) &&
                (depth_ff < req_ff.wall_depth);
      tex_v   = $signed({23'd0, req_ff.column}) - 35'(centre_ff) +
                $signed({20'd0, size_ff[15:1]});
      tex_num = 48'(tex_v[33:0]) * 48'(TEX_W_C);
      tex_d   = $signed({7'd0, first_row_ff, 8'd0}) -
                $signed({7'd0, cfg.screen_height, 7'd0}) +
                $signed({4'd0, size_ff, 7'd0});
      tex_den = 40'(tex_d[25:0]) * 40'(TEX_H_C);
      tr8     = div_quo[63:8];
   end

   // divider operands, dividend aligned to the top bit
   always_comb begin
      case (cmd.div_op)
         DIV_DEPTH: begin
            div_dividend = {ny_mag[47:0], 16'd0};
            div_divisor  = det_mag[47:0];
            div_count    = 7'd64;
         end
         DIV_CENTRE: begin
            div_dividend = {1'b0, cmag};
            div_divisor  = ny_mag[47:0];
            div_count    = 7'd64;
         end
         DIV_SIZE: begin
            div_dividend = {3'd0, cfg.screen_height, 48'd0};
            div_divisor  = {16'd0, depth_tmp_ff};
            div_count    = 7'd32;
         end
         DIV_STEP: begin
            div_dividend = {STEP_NUM, 32'd0};
            div_divisor  = {32'd0, size_ff};
            div_count    = 7'd32;
         end
         DIV_TEXCOL: begin
            div_dividend = {tex_num, 16'd0};
            div_divisor  = {32'd0, size_ff};
            div_count    = 7'd48;
         end
         DIV_TEXROW: begin
            div_dividend = {tex_den, 24'd0};
            div_divisor  = {32'd0, size_ff};
            div_count    = 7'd40;
         end
         default: begin
            div_dividend = {ny_mag[47:0], 16'd0};
            div_divisor  = det_mag[47:0];
            div_count    = 7'd64;
         end
      endcase
   end

   bsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.act == ACT_DIV_START),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .count    (div_count),
      .done     (div_done),
      .quotient (div_quo)
   );

   // result beat contents
   always_comb begin
      rsp_in           = '0;
      rsp_in.col_start = first_col_ff;
      rsp_in.col_end   = end_col_ff;
      if (req_ff.opcode == OP_COLUMN && draw_ff) begin
         rsp_in.draw          = 1'b1;
         rsp_in.row_start     = first_row_ff;
         rsp_in.row_end       = end_row_ff;
         rsp_in.tex_col       = tex_col_ff;
         rsp_in.tex_row_start = tex_row_ff;
         rsp_in.tex_row_step  = row_step_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.act)
         ACT_LOAD: req_ff <= req_data;
         ACT_REL: begin
            rx_ff <= (rx_sum[33:31] == 3'b000 || rx_sum[33:31] == 3'b111) ?
                     rx_sum[31:0] : (rx_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
            ry_ff <= (ry_sum[33:31] == 3'b000 || ry_sum[33:31] == 3'b111) ?
                     ry_sum[31:0] : (ry_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
         end
         ACT_MUL: begin
            prod_ff <= 64'(mag_a) * 64'(mag_b);
            pneg_ff <= op_a[31] ^ op_b[31];
         end
         ACT_ACC: begin
            case (cmd.mterm)
               MT_DET_A: det_ff <= term;
               MT_DET_B: det_ff <= det_ff - term;
               MT_NX_A:  nx_ff  <= term;
               MT_NX_B:  nx_ff  <= nx_ff - term;
               MT_NY_A:  ny_ff  <= term;
               MT_NY_B:  ny_ff  <= ny_ff - term;
               default:  det_ff <= term;
            endcase
         end
         ACT_CENTRE_MUL: begin
            cprod_ff <= cprod_in;
            cneg_ff  <= nxy_sum[49] ^ ny_ff[48];
         end
         ACT_DIV_STORE: begin
            case (cmd.div_op)
               DIV_DEPTH:  depth_tmp_ff <= (|div_quo[63:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
               DIV_SIZE:   size_tmp_ff  <= (|div_quo[63:16]) ? 16'hFFFF : div_quo[15:0];
               DIV_TEXCOL: tex_col_ff   <= div_quo[11:0];
               DIV_TEXROW: tex_row_ff   <= (|tr8[55:16]) ? 32'hFFFF_FFFF : {tr8[15:0], 16'd0};
               default: ;
            endcase
         end
         ACT_COL_EVAL: begin
            draw_ff    <= draw_c;
            tex_col_ff <= 12'd0;
            tex_row_ff <= 32'd0;
         end
         ACT_RSP_LOAD: rsp_ff <= rsp_in;
         default: ;
      endcase
   end

   // sprite state
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= 32'd0;
         centre_ff    <= 32'sd0;
         size_ff      <= 16'd0;
         first_col_ff <= 12'd0;
         end_col_ff   <= 12'd0;
         first_row_ff <= 12'd0;
         end_row_ff   <= 12'd0;
         row_step_ff  <= 32'd0;
      end else begin
         case (cmd.act)
            ACT_CLEAR_ALL, ACT_CLEAR_KEEP: begin
               depth_ff     <= 32'd0;
               size_ff      <= 16'd0;
               first_col_ff <= 12'd0;
               end_col_ff   <= 12'd0;
               first_row_ff <= 12'd0;
               end_row_ff   <= 12'd0;
               row_step_ff  <= 32'd0;
               if (cmd.act == ACT_CLEAR_ALL) centre_ff <= 32'sd0;
            end
            ACT_GEOM: begin
               depth_ff     <= depth_tmp_ff;
               size_ff      <= size_tmp_ff;
               first_row_ff <= clamp12(35'(row_a_lim));
               end_row_ff   <= clamp12(35'(row_b_lim));
               first_col_ff <= clamp12(col_a_lim);
               end_col_ff   <= clamp12(col_b_lim);
            end
            ACT_DIV_STORE: begin
               case (cmd.div_op)
                  DIV_CENTRE: centre_ff   <= sat_centre(div_quo, cneg_ff);
                  DIV_STEP:   row_step_ff <= div_quo[31:0];
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // status to the controller
   always_comb begin
      status.is_column  = (req_ff.opcode == OP_COLUMN);
      status.proj_bad   = (det_ff == 49'sd0) || (ny_ff == 49'sd0) || (ny_ff[48] != det_ff[48]);
      status.depth_zero = (depth_tmp_ff == 32'd0);
      status.size_zero  = (size_tmp_ff == 16'd0);
      status.draw       = draw_c;
      status.texcol_pos = !tex_v[34] && (tex_v != 35'sd0);
      status.texrow_pos = !tex_d[26] && (tex_d != 27'sd0);
      status.div_done   = div_done;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/bsp_ctrl.sv
// controller: sequences the transform, the divisions and the result beat
// uses bsp_pkg command and status types
`default_nettype none

module bsp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire bsp_pkg::status_type status,
   output bsp_pkg::cmd_type         cmd
);

   import bsp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MUL,
      ST_ACC,
      ST_CHECK,
      ST_DIV_WAIT,
      ST_DEPTH_CHK,
      ST_CENTRE_START,
      ST_SIZE_START,
      ST_SIZE_CHK,
      ST_STEP_START,
      ST_COL_DRAW,
      ST_TEXROW_CHK,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   mterm_type  mterm_ff, mterm_in;
   div_op_type op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      mterm_in     = mterm_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.act      = ACT_NONE;
      cmd.div_op   = op_ff;
      cmd.mterm    = mterm_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.act  = ACT_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_column) begin
               cmd.act  = ACT_COL_EVAL;
               state_in = ST_COL_DRAW;
            end else begin
               cmd.act  = ACT_REL;
               mterm_in = MT_DET_A;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.act  = ACT_MUL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.act = ACT_ACC;
            state_in = ST_MUL;
            case (mterm_ff)
               MT_DET_A: mterm_in = MT_DET_B;
               MT_DET_B: mterm_in = MT_NX_A;
               MT_NX_A:  mterm_in = MT_NX_B;
               MT_NX_B:  mterm_in = MT_NY_A;
               MT_NY_A:  mterm_in = MT_NY_B;
               default:  state_in = ST_CHECK;
            endcase
         end
         ST_CHECK: begin
            if (status.proj_bad) begin
               cmd.act  = ACT_CLEAR_ALL;
               state_in = ST_FINISH;
            end else begin
               cmd.act    = ACT_DIV_START;
               cmd.div_op = DIV_DEPTH;
               op_in      = DIV_DEPTH;
               state_in   = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.act = ACT_DIV_STORE;
               case (op_ff)
                  DIV_DEPTH:  state_in = ST_DEPTH_CHK;
                  DIV_CENTRE: state_in = ST_SIZE_START;
                  DIV_SIZE:   state_in = ST_SIZE_CHK;
                  DIV_TEXCOL: state_in = ST_TEXROW_CHK;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_DEPTH_CHK: begin
            if (status.depth_zero) begin
               cmd.act  = ACT_CLEAR_ALL;
               state_in = ST_FINISH;
            end else begin
               cmd.act  = ACT_CENTRE_MUL;
               state_in = ST_CENTRE_START;
            end
         end
         ST_CENTRE_START: begin
            cmd.act    = ACT_DIV_START;
            cmd.div_op = DIV_CENTRE;
            op_in      = DIV_CENTRE;
            state_in   = ST_DIV_WAIT;
         end
         ST_SIZE_START: begin
            cmd.act    = ACT_DIV_START;
            cmd.div_op = DIV_SIZE;
            op_in      = DIV_SIZE;
            state_in   = ST_DIV_WAIT;
         end
         ST_SIZE_CHK: begin
            if (status.size_zero) begin
               cmd.act  = ACT_CLEAR_KEEP;
               state_in = ST_FINISH;
            end else begin
               cmd.act  = ACT_GEOM;
               state_in = ST_STEP_START;
            end
         end
         ST_STEP_START: begin
            cmd.act    = ACT_DIV_START;
            cmd.div_op = DIV_STEP;
            op_in      = DIV_STEP;
            state_in   = ST_DIV_WAIT;
         end
         ST_COL_DRAW: begin
            if (!status.draw) begin
               state_in = ST_FINISH;
            end else if (status.texcol_pos) begin
               cmd.act    = ACT_DIV_START;
               cmd.div_op = DIV_TEXCOL;
               op_in      = DIV_TEXCOL;
               state_in   = ST_DIV_WAIT;
            end else begin
               state_in = ST_TEXROW_CHK;
            end
         end
         ST_TEXROW_CHK: begin
            if (status.texrow_pos) begin
               cmd.act    = ACT_DIV_START;
               cmd.div_op = DIV_TEXROW;
               op_in      = DIV_TEXROW;
               state_in   = ST_DIV_WAIT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.act      = ACT_RSP_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mterm_ff     <= MT_DET_A;
         op_ff        <= DIV_DEPTH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mterm_ff     <= mterm_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hdl/billboard_sprite_projector.sv
// Billboard sprite projector for a raycaster, Q16.16 fixed point.
// Input channel req_*: a beat with opcode 0 loads a sprite position; the block
// moves it into camera space, stores depth, centre, size, column/row ranges and
// texture row step, and returns one beat with the clamped column range.
// A beat with opcode 1 queries one screen column against its wall depth and
// returns draw, row range, texture column, start texture row and row step.
// Result channel rsp_*: exactly one beat per input beat, in order.
// One item is worked on at a time; all divisions share one restoring divider
// that produces one quotient bit per cycle: a sprite beat takes six multiplies,
// then up to four divisions of 64, 64, 32 and 32 bits; a column beat takes no
// division when not drawn and up to two, of 48 and 40 bits, when drawn.
// The result sits in an output register, so the next beat is taken while a
// finished result waits; a stalled result holds the block before its next load.
// Reset (synchronous) restores the default screen and camera registers and
// clears the stored sprite. Configuration writes via csr_* are taken any time
// and must only be done while the block is idle.
// uses bsp_pkg, bsp_ctrl, bsp_dp
`default_nettype none

module billboard_sprite_projector #(
   parameter int unsigned TEX_W = 64,
   parameter int unsigned TEX_H = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire bsp_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output bsp_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [bsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [bsp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import bsp_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.player_x      <= RST_PLAYER_X;
         cfg_ff.player_y      <= RST_PLAYER_Y;
         cfg_ff.dir_x         <= RST_DIR_X;
         cfg_ff.dir_y         <= RST_DIR_Y;
         cfg_ff.plane_x       <= RST_PLANE_X;
         cfg_ff.plane_y       <= RST_PLANE_Y;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata[12:0];
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata[12:0];
            CSR_PLAYER_X:      cfg_ff.player_x      <= $signed(csr_wdata);
            CSR_PLAYER_Y:      cfg_ff.player_y      <= $signed(csr_wdata);
            CSR_DIR_X:         cfg_ff.dir_x         <= $signed(csr_wdata);
            CSR_DIR_Y:         cfg_ff.dir_y         <= $signed(csr_wdata);
            CSR_PLANE_X:       cfg_ff.plane_x       <= $signed(csr_wdata);
            CSR_PLANE_Y:       cfg_ff.plane_y       <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   bsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bsp_dp #(
      .TEX_W (TEX_W),
      .TEX_H (TEX_H)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench for billboard_sprite_projector: random and directed sprite and column beats
// a scoreboard class predicts each result from its own model of the projection math
// depends on bsp_pkg and billboard_sprite_projector
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bsp_pkg::*;

   localparam int unsigned TW = 64;
   localparam int unsigned TH = 64;
   localparam longint CYCLE_LIMIT = 2000000;

   // projection model and queue of expected results
   class sprite_board;
      longint scr_w, scr_h, pl_x, pl_y, d_x, d_y, pn_x, pn_y;
      longint depth, centre, size, fcol, ecol, frow, erow, rstep;
      rsp_type pending[$];
      int errors;

      function new();
         scr_w = 640; scr_h = 480; pl_x = 0; pl_y = 0;
         d_x = 65536; d_y = 0; pn_x = 0; pn_y = 43254;
         centre = 0; errors = 0;
         clear_sprite();
      endfunction

      function void clear_sprite();
         depth = 0; size = 0; rstep = 0;
         fcol = 0; ecol = 0; frow = 0; erow = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_SCREEN_WIDTH:  scr_w = v[12:0];
            CSR_SCREEN_HEIGHT: scr_h = v[12:0];
            CSR_PLAYER_X:      pl_x = longint'(signed'(v));
            CSR_PLAYER_Y:      pl_y = longint'(signed'(v));
            CSR_DIR_X:         d_x = longint'(signed'(v));
            CSR_DIR_Y:         d_y = longint'(signed'(v));
            CSR_PLANE_X:       pn_x = longint'(signed'(v));
            default:           pn_y = longint'(signed'(v));
         endcase
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint qmul(longint a, longint b);
         longint unsigned p;
         p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> 16;
         return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
      endfunction

      function longint clamp12(longint v);
         return v < 0 ? 0 : (v > 4095 ? 4095 : v);
      endfunction

      function void project(longint spx, longint spy);
         longint rx, ry, det, nx, ny, q, c, half, a, b;
         rx = sat32(spx - pl_x + 32768);
         ry = sat32(spy - pl_y + 32768);
         det = qmul(pn_x, d_y) - qmul(d_x, pn_y);
         nx = qmul(d_y, rx) - qmul(d_x, ry);
         ny = qmul(pn_x, ry) - qmul(pn_y, rx);
         clear_sprite();
         centre = 0;
         if (det == 0 || ny == 0 || ((ny < 0) != (det < 0))) return;
         q = longint'((longint'(unsigned'(ny < 0 ? -ny : ny)) << 16)
                      / (det < 0 ? -det : det));
         if (q == 0) return;
         if (q > 64'hFFFFFFFF) q = 64'hFFFFFFFF;
         c = sat32(((scr_w >> 1) * (ny + nx)) / ny);
         centre = c;
         size = (scr_h << 16) / q;
         if (size > 65535) size = 65535;
         if (size == 0) return;
         depth = q;
         half = size >> 1;
         a = scr_h / 2 - half; b = scr_h / 2 + half;
         if (a < 0) a = 0;
         if (b >= scr_h) b = scr_h - 1;
         frow = clamp12(a); erow = clamp12(b);
         a = c - half; b = c + half;
         if (a < 0) a = 0;
         if (b >= scr_w) b = scr_w - 1;
         fcol = clamp12(a); ecol = clamp12(b);
         rstep = (longint'(TH) << 16) / size;
      endfunction

      // note an accepted input beat
      function void note_request(req_type r);
         rsp_type e;
         longint col, t, d, rr;
         e = '0;
         if (r.opcode == OP_SPRITE) begin
            project(longint'(r.sprite_x), longint'(r.sprite_y));
         end else begin
            col = r.column;
            if (size > 0 && depth > 0 && col >= fcol && col < ecol && col < scr_w
                && depth < longint'(r.wall_depth)) begin
               e.draw = 1'b1;
               e.row_start = frow[11:0];
               e.row_end = erow[11:0];
               t = (col - (centre - (size >> 1))) * TW / size;
               e.tex_col = t < 0 ? 12'd0 : t[11:0];
               d = frow * 256 - scr_h * 128 + size * 128;
               if (d > 0) begin
                  rr = ((d * TH) / size) / 256;
                  rr = rr << 16;
                  e.tex_row_start = rr > 64'hFFFFFFFF ? 32'hFFFFFFFF : rr[31:0];
               end
               e.tex_row_step = rstep[31:0];
            end
         end
         e.col_start = fcol[11:0];
         e.col_end = ecol[11:0];
         pending.push_back(e);
      endfunction

      // check one result beat against the oldest expectation
      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, e, got);
            if (got.draw !== e.draw) $display("  draw %h %h", e.draw, got.draw);
            if (got.col_start !== e.col_start || got.col_end !== e.col_end)
               $display("  cols %0d..%0d %0d..%0d", e.col_start, e.col_end,
                        got.col_start, got.col_end);
            if (got.row_start !== e.row_start || got.row_end !== e.row_end)
               $display("  rows %0d..%0d %0d..%0d", e.row_start, e.row_end,
                        got.row_start, got.row_end);
            if (got.tex_col !== e.tex_col) $display("  tex_col %0d %0d", e.tex_col, got.tex_col);
            if (got.tex_row_start !== e.tex_row_start)
               $display("  tex_row_start %h %h", e.tex_row_start, got.tex_row_start);
            if (got.tex_row_step !== e.tex_row_step)
               $display("  tex_row_step %h %h", e.tex_row_step, got.tex_row_step);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_wr_en;
   req_type req_data;
   rsp_type rsp_data;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   sprite_board board;
   bit quiet;
   longint cycles;

   billboard_sprite_projector dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("** billboard_sprite_projector: FAILED **");
            $finish;
         end
      end
   end

   // result side: random stall and checking
   initial begin
      board = new();
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 17);
      end
   end

   // one register write; the caller drops the write enable after its last write
   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
   endtask

   // send one beat, with an optional idle gap before it
   task automatic send(req_type r);
      while (!quiet && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_sprite(logic [31:0] x, logic [31:0] y);
      req_type r;
      r = '0; r.opcode = OP_SPRITE; r.sprite_x = x; r.sprite_y = y;
      r.column = 12'($urandom); r.wall_depth = $urandom;
      send(r);
   endtask

   task automatic send_column(logic [11:0] c, logic [31:0] w);
      req_type r;
      r = '0; r.opcode = OP_COLUMN; r.column = c; r.wall_depth = w;
      r.sprite_x = $urandom; r.sprite_y = $urandom;
      send(r);
   endtask

   // random sprite, mostly near the camera, then a burst of column queries mostly over it
   task automatic scene_burst(int n);
      int unsigned w;
      if ($urandom_range(9) == 0) send_sprite($urandom, $urandom);
      else send_sprite(32'($urandom_range(65536 * 40) + 65536),
                       32'(int'($urandom_range(65536 * 40)) - 65536 * 20));
      for (int k = 0; k < n; k++) begin
         w = ($urandom_range(3) == 0) ? $urandom : $urandom_range(65536 * 64);
         if ($urandom_range(7) == 0) send_column(12'($urandom), w);
         else send_column(12'(int'(board.fcol) + int'($urandom_range(
                  board.ecol - board.fcol + 2)) - 1), w);
      end
   endtask

   // one camera setup, all registers written
   task automatic set_camera(int w, int h, int px, int py, int dx, int dy,
                             int nx, int ny);
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, h);
      write_csr(CSR_PLAYER_X, px);
      write_csr(CSR_PLAYER_Y, py);
      write_csr(CSR_DIR_X, dx);
      write_csr(CSR_DIR_Y, dy);
      write_csr(CSR_PLANE_X, nx);
      write_csr(CSR_PLANE_Y, ny);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int sent;
      reset = 1'b1; req_valid = 1'b0; req_data = '0; quiet = 1'b0;
      csr_wr_en = 1'b0; csr_index = '0; csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: columns before any sprite, then edge sprites
      send_column(12'd0, 32'hFFFFFFFF);
      send_sprite(32'sd196608, 32'sd0);
      send_column(12'd0, 32'hFFFFFFFF);
      send_column(12'd320, 32'hFFFFFFFF);
      send_column(12'd320, 32'd0);
      send_column(12'd4095, 32'hFFFFFFFF);
      send_sprite(32'sd65536, 32'sd0);          // very close, large size
      send_column(12'd0, 32'hFFFFFFFF);
      send_column(12'd100, 32'hFFFFFFFF);
      send_sprite(32'h7FFFFFFF, 32'h80000000);  // saturated relative x position
      send_column(12'd100, 32'hFFFFFFFF);
      send_sprite(-32'sd196608, 32'sd0);        // behind the camera
      send_column(12'd320, 32'hFFFFFFFF);
      send_sprite(32'sd196608, 32'sd400000);    // off to the side
      send_column(12'd639, 32'hFFFFFFFF);
      send_sprite(32'h7FFF0000, 32'sd0);        // far away, zero size
      send_column(12'd320, 32'hFFFFFFFF);
      go_idle();

      // directed: zero determinant, zero screen size, extremes
      set_camera(0, 0, 0, 0, 65536, 0, 65536, 0);
      send_sprite(32'sd196608, 32'sd0);
      send_column(12'd0, 32'hFFFFFFFF);
      go_idle();
      set_camera(4096, 4096, 0, 0, 65536, 0, 0, 43254);
      send_sprite(32'sd131072, 32'sd0);
      send_column(12'd2048, 32'hFFFFFFFF);
      send_column(12'd0, 32'hFFFFFFFF);
      go_idle();
      set_camera(1, 1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h80000000);
      send_sprite(32'sd0, 32'sd0);
      send_column(12'd0, 32'hFFFFFFFF);
      go_idle();

      // random phases over several camera setups
      sent = 0;
      for (int ph = 0; ph < 12; ph++) begin
         quiet = (ph == 3);
         case (ph % 4)
            0: set_camera(640, 480, 0, 0, 65536, 0, 0, 43254);
            1: set_camera($urandom_range(1, 4096), $urandom_range(1, 4096),
                          int'($urandom_range(65536 * 20)) - 65536 * 10,
                          int'($urandom_range(65536 * 20)) - 65536 * 10,
                          65536, 0, 0, int'($urandom_range(20000, 90000)));
            2: set_camera($urandom_range(1, 300), $urandom_range(1, 300), 0, 0,
                          $urandom_range(30000, 70000), $urandom_range(20000),
                          $urandom_range(20000), $urandom_range(20000, 60000));
            default: set_camera($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
         endcase
         while (sent < (ph + 1) * 152) begin
            scene_burst($urandom_range(2, 12));
            sent += 8;
         end
         go_idle();
      end
      quiet = 1'b0;

      if (board.errors == 0 && board.pending.size() == 0)
         $display("** billboard_sprite_projector: PASSED **");
      else
         $display("** billboard_sprite_projector: FAILED **");
      $finish;
   end
endmodule

`default_nettype wire
